[rtl/bldq_pkg.sv]
// Shared types and constants of the bounded linked deque.
package bldq_pkg;

	// Operation codes carried by the opcode field.
	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_MOVE_BACK  = 3'd4,
		OP_NOP        = 3'd5
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_EMPTY      = 2'd2,
		STAT_BAD_HANDLE = 2'd3
	} status_t;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_EXEC  = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	// Field write enables of the link memory.
	typedef struct packed {
		logic prev;
		logic next;
	} link_we_t;

	// Configuration port.
	localparam int   ADDR_W       = 3;
	localparam int   CAP_W        = 7;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

[rtl/bldq_link_mem.sv]
// Link memory: previous and next slot of every entry, with field write enables.
module bldq_link_mem #(
	parameter int SLOTS = 64,
	localparam int HW = $clog2(SLOTS)
) (
	input  logic               clk,
	input  bldq_pkg::link_we_t we,
	input  logic [HW-1:0]      waddr,
	input  logic [HW-1:0]      wprev,
	input  logic [HW-1:0]      wnext,
	input  logic               re,
	input  logic [HW-1:0]      raddr,
	output logic [HW-1:0]      rprev,
	output logic [HW-1:0]      rnext
);

	// Each word holds the previous link in the upper half and the next link below.
	logic [2*HW-1:0] mem [SLOTS];

	// Write either field on its own.
	always_ff @(posedge clk) begin
		if (we.prev) begin
			mem[waddr][2*HW-1:HW] <= wprev;
		end
		if (we.next) begin
			mem[waddr][HW-1:0] <= wnext;
		end
	end

	// Registered read; the data hold until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rprev <= mem[raddr][2*HW-1:HW];
			rnext <= mem[raddr][HW-1:0];
		end
	end

endmodule

[rtl/bldq_data_mem.sv]
// Entry memory: key and value of every slot.
module bldq_data_mem #(
	parameter int SLOTS = 64,
	parameter int DATA_WIDTH = 32,
	localparam int HW = $clog2(SLOTS)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [HW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wkey,
	input  logic [DATA_WIDTH-1:0] wval,
	input  logic                  re,
	input  logic [HW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rkey,
	output logic [DATA_WIDTH-1:0] rval
);

	logic [2*DATA_WIDTH-1:0] mem [SLOTS];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wkey, wval};
		end
	end

	// Registered read; the data hold until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rkey <= mem[raddr][2*DATA_WIDTH-1:DATA_WIDTH];
			rval <= mem[raddr][DATA_WIDTH-1:0];
		end
	end

endmodule

[rtl/bldq_free_find.sv]
// Lowest free slot search over the used bits, in two levels with a register between.
module bldq_free_find #(
	parameter int SLOTS = 64,
	localparam int HW = $clog2(SLOTS)
) (
	input  logic             clk,
	input  logic [SLOTS-1:0] used,
	output logic [HW-1:0]    lowest
);

	localparam int GW = 8;
	localparam int NG = (SLOTS + GW - 1) / GW;
	localparam int PW = NG * GW;

	logic [PW-1:0] free_pad;
	logic          grp_any [NG];
	logic [2:0]    grp_off [NG];
	logic          grp_any_q [NG];
	logic [2:0]    grp_off_q [NG];

	// Slots beyond the table read as taken.
	assign free_pad = PW'(~used);

	// First level: for every group of eight, whether one is free and the lowest one.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = |free_pad[g*GW +: GW];
			grp_off[g] = 3'd0;
			for (int b = GW - 1; b >= 0; b--) begin
				if (free_pad[g*GW + b]) begin
					grp_off[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			grp_any_q[g] <= grp_any[g];
			grp_off_q[g] <= grp_off[g];
		end
	end

	// Second level: the lowest group with a free slot.
	always_comb begin
		lowest = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				lowest = HW'(g * GW + int'(grp_off_q[g]));
			end
		end
	end

endmodule

[rtl/bounded_linked_deque_move_to_back_core.sv]
// Top level of the bounded linked deque: sequencer, list registers and configuration port.
//
//  channel   handshake                      payload
//  command   start / busy, taken when !busy  opcode, entry_key, entry_value, slot_handle
//  result    done, one cycle, cannot stall   status, new_handle, out_key, out_value,
//                                            entry_total, is_empty, is_full, front/back
//  config    APB write, pready always high   paddr, pwdata, prdata
//
// Every command runs through acceptance with the link read, the data read and execute,
// and the result shows on the cycle after execute. Extra link writes then queue for the
// single write port: one for a push onto a non-empty list, three for a move that changes
// the order; busy stays high until those are done. Pops and no-ops queue none.
// Reset clears the used bits, list pointers and count at once, so no clearing pass runs.
// The receiver cannot stall: done is high for exactly one cycle for each result.
module bounded_linked_deque_move_to_back_core #(
	parameter int SLOTS = 64,
	parameter int DATA_WIDTH = 32,
	localparam int HW = $clog2(SLOTS),
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Command channel.
	input  logic                            start,
	output logic                            busy,
	input  logic [2:0]                      opcode,
	input  logic signed [DATA_WIDTH-1:0]    entry_key,
	input  logic signed [DATA_WIDTH-1:0]    entry_value,
	input  logic [HW-1:0]                   slot_handle,
	// Result channel.
	output logic                            done,
	output logic [1:0]                      status,
	output logic [HW-1:0]                   new_handle,
	output logic signed [DATA_WIDTH-1:0]    out_key,
	output logic signed [DATA_WIDTH-1:0]    out_value,
	output logic [CW-1:0]                   entry_total,
	output logic                            is_empty,
	output logic                            is_full,
	output logic signed [DATA_WIDTH-1:0]    front_key,
	output logic signed [DATA_WIDTH-1:0]    front_value,
	output logic signed [DATA_WIDTH-1:0]    back_key,
	output logic signed [DATA_WIDTH-1:0]    back_value,
	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bldq_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int EW = (CW > bldq_pkg::CAP_W) ? CW : bldq_pkg::CAP_W;
	localparam int DW = DATA_WIDTH;

	// One pending write into the link memory.
	typedef struct packed {
		bldq_pkg::link_we_t we;
		logic [HW-1:0]      addr;
		logic [HW-1:0]      prev;
		logic [HW-1:0]      next;
	} lwr_t;

	function automatic lwr_t lw_entry(input logic wp, input logic wn,
			input logic [HW-1:0] a, input logic [HW-1:0] p, input logic [HW-1:0] n);
		lwr_t e;
		e.we.prev = wp;
		e.we.next = wn;
		e.addr    = a;
		e.prev    = p;
		e.next    = n;
		return e;
	endfunction

	// Control state.
	bldq_pkg::state_t state_q;
	logic [HW-1:0]    first_q, last_q;
	logic [CW-1:0]    count_q;
	logic [SLOTS-1:0] used_q;
	logic [bldq_pkg::CAP_W-1:0] cap_q;
	logic [1:0]       wleft_q;
	logic             done_q;

	// Held command and cached end entries.
	bldq_pkg::op_t    op_q;
	logic [DW-1:0]    key_q, val_q;
	logic [HW-1:0]    hnd_q;
	logic [HW-1:0]    lf_q;
	logic [DW-1:0]    hkey_q, hval_q;
	logic [DW-1:0]    fk_q, fv_q, bk_q, bv_q;
	lwr_t             wq_q [3];

	// Result registers.
	bldq_pkg::status_t status_q;
	logic [HW-1:0]    new_handle_q;
	logic [DW-1:0]    out_key_q, out_value_q;
	logic [CW-1:0]    entry_total_q;
	logic             is_empty_q, is_full_q;
	logic [DW-1:0]    front_key_q, front_value_q, back_key_q, back_value_q;

	// Memory and search connections.
	logic             accept;
	logic [HW-1:0]    lnk_raddr, lnk_prev, lnk_next;
	lwr_t             lw;
	logic             dat_re;
	logic [HW-1:0]    dat_raddr;
	logic [DW-1:0]    dat_rkey, dat_rval;
	logic             dat_we;
	logic [HW-1:0]    lf_w;

	// Execute step results.
	bldq_pkg::status_t stat_n;
	logic [HW-1:0]    hnd_n, first_n, last_n;
	logic [DW-1:0]    okey_n, oval_n, fk_n, fv_n, bk_n, bv_n;
	logic [CW-1:0]    cnt_n;
	logic [SLOTS-1:0] used_n;
	lwr_t             wl [4];
	logic [1:0]       wleft_n;
	logic             h_ok;
	logic [EW-1:0]    eff_cap, cap_e;
	logic             full_pre;
	bldq_pkg::state_t state_n;
	logic             cfg_wr;

	assign accept = start && !busy;
	assign busy   = (state_q != bldq_pkg::S_IDLE);

	// Link read at acceptance: the end being popped or the handle being moved.
	always_comb begin
		case (bldq_pkg::op_t'(opcode))
			bldq_pkg::OP_POP_BACK:  lnk_raddr = last_q;
			bldq_pkg::OP_POP_FRONT: lnk_raddr = first_q;
			default:                lnk_raddr = slot_handle;
		endcase
	end

	// Entry read: the handle at acceptance, then the neighbour that becomes an end.
	assign dat_re    = accept || (state_q == bldq_pkg::S_READ);
	assign dat_raddr = (state_q == bldq_pkg::S_READ)
		? ((op_q == bldq_pkg::OP_POP_BACK) ? lnk_prev : lnk_next)
		: slot_handle;

	// Link writes: the first in the execute cycle, the rest from the queue.
	always_comb begin
		if (state_q == bldq_pkg::S_EXEC) begin
			lw = wl[0];
		end else if (state_q == bldq_pkg::S_WRITE) begin
			lw = wq_q[0];
		end else begin
			lw = '0;
		end
	end

	bldq_link_mem #(.SLOTS(SLOTS)) u_link_mem (
		.clk   (clk),
		.we    (lw.we),
		.waddr (lw.addr),
		.wprev (lw.prev),
		.wnext (lw.next),
		.re    (accept),
		.raddr (lnk_raddr),
		.rprev (lnk_prev),
		.rnext (lnk_next)
	);

	bldq_data_mem #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH)) u_data_mem (
		.clk   (clk),
		.we    (dat_we),
		.waddr (lf_q),
		.wkey  (key_q),
		.wval  (val_q),
		.re    (dat_re),
		.raddr (dat_raddr),
		.rkey  (dat_rkey),
		.rval  (dat_rval)
	);

	bldq_free_find #(.SLOTS(SLOTS)) u_free_find (
		.clk    (clk),
		.used   (used_q),
		.lowest (lf_w)
	);

	// Effective capacity is the register saturated to the table size.
	assign cap_e    = EW'(cap_q);
	assign eff_cap  = (cap_e > EW'(SLOTS)) ? EW'(SLOTS) : cap_e;
	assign full_pre = EW'(count_q) >= eff_cap;
	assign h_ok     = ({1'b0, hnd_q} < (HW+1)'(SLOTS)) && used_q[hnd_q];

	// Execute: new list state, link writes and result fields.
	always_comb begin
		stat_n  = bldq_pkg::STAT_OK;
		hnd_n   = '0;
		okey_n  = '0;
		oval_n  = '0;
		first_n = first_q;
		last_n  = last_q;
		cnt_n   = count_q;
		used_n  = used_q;
		fk_n    = fk_q;
		fv_n    = fv_q;
		bk_n    = bk_q;
		bv_n    = bv_q;
		dat_we  = 1'b0;
		wleft_n = 2'd0;
		for (int i = 0; i < 4; i++) begin
			wl[i] = '0;
		end
		case (op_q)
			bldq_pkg::OP_PUSH_BACK, bldq_pkg::OP_PUSH_FRONT: begin
				if (full_pre) begin
					stat_n = bldq_pkg::STAT_FULL;
				end else begin
					dat_we       = (state_q == bldq_pkg::S_EXEC);
					used_n[lf_q] = 1'b1;
					hnd_n        = lf_q;
					cnt_n        = count_q + CW'(1);
					if (count_q == '0) begin
						first_n = lf_q;
						last_n  = lf_q;
						fk_n    = key_q;
						fv_n    = val_q;
						bk_n    = key_q;
						bv_n    = val_q;
					end else if (op_q == bldq_pkg::OP_PUSH_BACK) begin
						wl[0]   = lw_entry(1'b1, 1'b0, lf_q, last_q, '0);
						wl[1]   = lw_entry(1'b0, 1'b1, last_q, '0, lf_q);
						wleft_n = 2'd1;
						last_n  = lf_q;
						bk_n    = key_q;
						bv_n    = val_q;
					end else begin
						wl[0]   = lw_entry(1'b0, 1'b1, lf_q, '0, first_q);
						wl[1]   = lw_entry(1'b1, 1'b0, first_q, lf_q, '0);
						wleft_n = 2'd1;
						first_n = lf_q;
						fk_n    = key_q;
						fv_n    = val_q;
					end
				end
			end
			bldq_pkg::OP_POP_BACK, bldq_pkg::OP_POP_FRONT: begin
				if (count_q == '0) begin
					stat_n = bldq_pkg::STAT_EMPTY;
					okey_n = '1;
					oval_n = '1;
				end else begin
					cnt_n = count_q - CW'(1);
					if (op_q == bldq_pkg::OP_POP_BACK) begin
						okey_n         = bk_q;
						oval_n         = bv_q;
						used_n[last_q] = 1'b0;
						last_n         = lnk_prev;
						bk_n           = dat_rkey;
						bv_n           = dat_rval;
					end else begin
						okey_n          = fk_q;
						oval_n          = fv_q;
						used_n[first_q] = 1'b0;
						first_n         = lnk_next;
						fk_n            = dat_rkey;
						fv_n            = dat_rval;
					end
					// The last entry leaves both pointers at slot zero.
					if (count_q == CW'(1)) begin
						first_n = '0;
						last_n  = '0;
					end
				end
			end
			bldq_pkg::OP_MOVE_BACK: begin
				if (!h_ok) begin
					stat_n = bldq_pkg::STAT_BAD_HANDLE;
				end else if (hnd_q != last_q) begin
					// Unlink the entry, then hang it after the old back.
					if (hnd_q == first_q) begin
						first_n = lnk_next;
						fk_n    = dat_rkey;
						fv_n    = dat_rval;
					end else begin
						wl[0] = lw_entry(1'b0, 1'b1, lnk_prev, '0, lnk_next);
					end
					wl[1]   = lw_entry(1'b1, 1'b0, lnk_next, lnk_prev, '0);
					wl[2]   = lw_entry(1'b1, 1'b0, hnd_q, last_q, '0);
					wl[3]   = lw_entry(1'b0, 1'b1, last_q, '0, hnd_q);
					wleft_n = 2'd3;
					last_n  = hnd_q;
					bk_n    = hkey_q;
					bv_n    = hval_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_comb begin
		state_n = state_q;
		case (state_q)
			bldq_pkg::S_IDLE: begin
				if (start) begin
					state_n = bldq_pkg::S_READ;
				end
			end
			bldq_pkg::S_READ: begin
				state_n = bldq_pkg::S_EXEC;
			end
			bldq_pkg::S_EXEC: begin
				state_n = (wleft_n != 2'd0) ? bldq_pkg::S_WRITE : bldq_pkg::S_IDLE;
			end
			bldq_pkg::S_WRITE: begin
				if (wleft_q == 2'd1) begin
					state_n = bldq_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = bldq_pkg::S_IDLE;
			end
		endcase
	end

	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == bldq_pkg::REG_CAPACITY);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bldq_pkg::S_IDLE;
			first_q <= '0;
			last_q  <= '0;
			count_q <= '0;
			used_q  <= '0;
			cap_q   <= bldq_pkg::CAP_RESET;
			wleft_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (state_q == bldq_pkg::S_EXEC);
			if (cfg_wr) begin
				cap_q <= pwdata[bldq_pkg::CAP_W-1:0];
			end
			if (state_q == bldq_pkg::S_EXEC) begin
				first_q <= first_n;
				last_q  <= last_n;
				count_q <= cnt_n;
				used_q  <= used_n;
				wleft_q <= wleft_n;
			end else if (state_q == bldq_pkg::S_WRITE) begin
				wleft_q <= wleft_q - 2'd1;
			end
		end
	end

	// Command, cached entries, write queue and result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= bldq_pkg::op_t'(opcode);
			key_q <= entry_key;
			val_q <= entry_value;
			hnd_q <= slot_handle;
		end
		if (state_q == bldq_pkg::S_READ) begin
			lf_q   <= lf_w;
			hkey_q <= dat_rkey;
			hval_q <= dat_rval;
		end
		if (state_q == bldq_pkg::S_EXEC) begin
			fk_q          <= fk_n;
			fv_q          <= fv_n;
			bk_q          <= bk_n;
			bv_q          <= bv_n;
			wq_q[0]       <= wl[1];
			wq_q[1]       <= wl[2];
			wq_q[2]       <= wl[3];
			status_q      <= stat_n;
			new_handle_q  <= hnd_n;
			out_key_q     <= okey_n;
			out_value_q   <= oval_n;
			entry_total_q <= cnt_n;
			is_empty_q    <= (cnt_n == '0);
			is_full_q     <= (EW'(cnt_n) >= eff_cap);
			front_key_q   <= (cnt_n == '0) ? '1 : fk_n;
			front_value_q <= (cnt_n == '0) ? '1 : fv_n;
			back_key_q    <= (cnt_n == '0) ? '1 : bk_n;
			back_value_q  <= (cnt_n == '0) ? '1 : bv_n;
		end else if (state_q == bldq_pkg::S_WRITE) begin
			wq_q[0] <= wq_q[1];
			wq_q[1] <= wq_q[2];
		end
	end

	// Result ports.
	assign done        = done_q;
	assign status      = status_q;
	assign new_handle  = new_handle_q;
	assign out_key     = out_key_q;
	assign out_value   = out_value_q;
	assign entry_total = entry_total_q;
	assign is_empty    = is_empty_q;
	assign is_full     = is_full_q;
	assign front_key   = front_key_q;
	assign front_value = front_value_q;
	assign back_key    = back_key_q;
	assign back_value  = back_value_q;

	// Register read-back.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == bldq_pkg::REG_CAPACITY) ? 32'(cap_q) : 32'd0;

endmodule

[rtl/bldq_checker.sv]
// Port-level checks of the bounded linked deque, bound to the top level.
module bldq_checker #(
	parameter int SLOTS = 64,
	parameter int DATA_WIDTH = 32,
	localparam int CW = $clog2(SLOTS + 1)
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [1:0]            status,
	input logic [CW-1:0]         entry_total,
	input logic                  is_empty,
	input logic                  is_full,
	input logic [DATA_WIDTH-1:0] front_key,
	input logic [DATA_WIDTH-1:0] back_key
);

	// Every accepted command gives its result after the read and execute steps.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result transfer missing three cycles after a command transfer");

	// A result never appears unless a command was being worked on.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result transfer without a command in progress");

	// The empty flag, count and end entries agree.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_empty) |-> (entry_total == '0) && (front_key == '1) && (back_key == '1))
		else $error("empty result with a count or end entries");

	// A refused push leaves the list full.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == bldq_pkg::STAT_FULL)) |-> is_full)
		else $error("push reported full while the list is not full");

	// A pop that finds nothing leaves the list empty.
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == bldq_pkg::STAT_EMPTY)) |-> is_empty)
		else $error("pop reported empty while entries remain");

endmodule

bind bounded_linked_deque_move_to_back_core bldq_checker #(
	.SLOTS(SLOTS),
	.DATA_WIDTH(DATA_WIDTH)
) u_bldq_checker (.*);
